// ----- src/mdcp_pkg.sv -----
package mdcp_pkg;

  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_INDEX_W     = 3;

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_COMMAND,
    PH_SIZE,
    PH_OFFSET,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ACT_SET_SIZE  = 3'd0,
    ACT_OVERWRITE = 3'd1,
    ACT_XOR       = 3'd2,
    ACT_END       = 3'd3,
    ACT_ERROR     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TOO_SHORT  = 3'd1,
    ERR_BAD_VER    = 3'd2,
    ERR_TRUNCATED  = 3'd3,
    ERR_COMPRESSED = 3'd4
  } err_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VERSION    = 3'd0,
    CFG_SIZE       = 3'd1,
    CFG_COMPRESSED = 3'd2,
    CFG_OVERWRITE  = 3'd3,
    CFG_XOR        = 3'd4,
    CFG_END        = 3'd5
  } cfg_reg_t;

  // Results caused by one stream byte: an optional main result, then an
  // optional truncation error.
  typedef struct packed {
    logic        has_main;
    action_t     action;
    logic [31:0] addr;
    logic [31:0] value;
    err_t        err;
    logic        has_trunc;
  } entry_t;

endpackage

// ----- src/memory_delta_command_parser_unit.sv -----
// An accepted byte's results pass through the queue and the output registers before they show.
// Throughput: one stream byte per cycle while in_ready is high; one output result per cycle
// while out_ready is high, so a byte that both writes and is cut short gives two results.
// A four-entry queue between parser and output stage absorbs output stalls.
// Reset (rst, synchronous): parser expects a version byte, codes take their defaults,
// queue and output are emptied.
module memory_delta_command_parser_unit #(
  parameter int ADDR_WIDTH  = mdcp_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mdcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mdcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       stream_byte,
  input  logic                             stream_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       action,
  output logic [31:0]                      target_address,
  output logic [31:0]                      action_value,
  output logic [2:0]                       error_kind,
  output logic                             run_last
);

  mdcp_pkg::entry_t push_entry, head;
  logic push, pop, empty, full, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  mdcp_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .stream_byte (stream_byte),
    .stream_last (stream_last),
    .push        (push),
    .entry       (push_entry)
  );

  mdcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  mdcp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .action         (action),
    .target_address (target_address),
    .action_value   (action_value),
    .error_kind     (error_kind),
    .run_last       (run_last)
  );

endmodule

// ----- src/mdcp_front.sv -----
module mdcp_front #(
  parameter int ADDR_WIDTH = mdcp_pkg::ADDR_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mdcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               accept,
  input  logic [7:0]                         stream_byte,
  input  logic                               stream_last,
  output logic                               push,
  output mdcp_pkg::entry_t                   entry
);

  logic [7:0] version_code, size_code, compressed_code;
  logic [7:0] overwrite_code, xor_code, end_code;

  mdcp_pkg::phase_t      phase, phase_next, phase_step;
  logic [1:0]            field_cnt, field_cnt_next;
  logic [23:0]           field_acc, field_acc_next;
  logic                  is_xor, is_xor_next;
  logic [ADDR_WIDTH-1:0] block_offset, block_offset_next;
  logic [31:0]           bytes_remaining, bytes_remaining_next;

  logic [31:0] full_field;
  logic        field_done;
  logic        trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      version_code    <= 8'd1;
      size_code       <= 8'd1;
      compressed_code <= 8'd2;
      overwrite_code  <= 8'd3;
      xor_code        <= 8'd4;
      end_code        <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mdcp_pkg::CFG_VERSION:    version_code    <= cfg_data;
        mdcp_pkg::CFG_SIZE:       size_code       <= cfg_data;
        mdcp_pkg::CFG_COMPRESSED: compressed_code <= cfg_data;
        mdcp_pkg::CFG_OVERWRITE:  overwrite_code  <= cfg_data;
        mdcp_pkg::CFG_XOR:        xor_code        <= cfg_data;
        mdcp_pkg::CFG_END:        end_code        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mdcp_pkg::PH_VERSION;
      field_cnt       <= '0;
      field_acc       <= '0;
      is_xor          <= 1'b0;
      block_offset    <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      field_cnt       <= field_cnt_next;
      field_acc       <= field_acc_next;
      is_xor          <= is_xor_next;
      block_offset    <= block_offset_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  assign full_field = {stream_byte, field_acc};
  assign field_done = (field_cnt == 2'd3);

  always_comb begin
    phase_step           = phase;
    field_cnt_next       = field_cnt;
    field_acc_next       = field_acc;
    is_xor_next          = is_xor;
    block_offset_next    = block_offset;
    bytes_remaining_next = bytes_remaining;
    entry                = '0;
    entry.action         = mdcp_pkg::ACT_SET_SIZE;
    entry.err            = mdcp_pkg::ERR_NONE;

    if (phase == mdcp_pkg::PH_SIZE || phase == mdcp_pkg::PH_OFFSET ||
        phase == mdcp_pkg::PH_LENGTH) begin
      if (field_done) begin
        field_cnt_next = '0;
        field_acc_next = '0;
      end else begin
        field_cnt_next = field_cnt + 2'd1;
        case (field_cnt)
          2'd0:    field_acc_next[7:0]   = stream_byte;
          2'd1:    field_acc_next[15:8]  = stream_byte;
          default: field_acc_next[23:16] = stream_byte;
        endcase
      end
    end

    case (phase)
      mdcp_pkg::PH_VERSION: begin
        if (stream_last) begin
          entry.has_main = 1'b1;
          entry.action   = mdcp_pkg::ACT_ERROR;
          entry.err      = mdcp_pkg::ERR_TOO_SHORT;
        end else if (stream_byte != version_code) begin
          entry.has_main = 1'b1;
          entry.action   = mdcp_pkg::ACT_ERROR;
          entry.err      = mdcp_pkg::ERR_BAD_VER;
          phase_step     = mdcp_pkg::PH_DRAIN;
        end else begin
          phase_step = mdcp_pkg::PH_COMMAND;
        end
      end
      mdcp_pkg::PH_COMMAND: begin
        field_cnt_next = '0;
        field_acc_next = '0;
        if (stream_byte == size_code) begin
          phase_step = mdcp_pkg::PH_SIZE;
        end else if (stream_byte == compressed_code) begin
          entry.has_main = 1'b1;
          entry.action   = mdcp_pkg::ACT_ERROR;
          entry.err      = mdcp_pkg::ERR_COMPRESSED;
          phase_step     = mdcp_pkg::PH_DRAIN;
        end else if (stream_byte == overwrite_code) begin
          is_xor_next = 1'b0;
          phase_step  = mdcp_pkg::PH_OFFSET;
        end else if (stream_byte == xor_code) begin
          is_xor_next = 1'b1;
          phase_step  = mdcp_pkg::PH_OFFSET;
        end else if (stream_byte == end_code) begin
          entry.has_main = 1'b1;
          entry.action   = mdcp_pkg::ACT_END;
          phase_step     = mdcp_pkg::PH_DRAIN;
        end
      end
      mdcp_pkg::PH_SIZE: begin
        if (field_done) begin
          entry.has_main = 1'b1;
          entry.action   = mdcp_pkg::ACT_SET_SIZE;
          entry.value    = full_field;
          phase_step     = mdcp_pkg::PH_COMMAND;
        end
      end
      mdcp_pkg::PH_OFFSET: begin
        if (field_done) begin
          block_offset_next = full_field[ADDR_WIDTH-1:0];
          phase_step        = mdcp_pkg::PH_LENGTH;
        end
      end
      mdcp_pkg::PH_LENGTH: begin
        if (field_done) begin
          bytes_remaining_next = full_field;
          phase_step = (full_field != 32'd0) ? mdcp_pkg::PH_PAYLOAD
                                             : mdcp_pkg::PH_COMMAND;
        end
      end
      mdcp_pkg::PH_PAYLOAD: begin
        entry.has_main       = 1'b1;
        entry.action         = is_xor ? mdcp_pkg::ACT_XOR : mdcp_pkg::ACT_OVERWRITE;
        entry.addr           = 32'(block_offset);
        entry.value          = {24'd0, stream_byte};
        block_offset_next    = block_offset + ADDR_WIDTH'(1);
        bytes_remaining_next = bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          phase_step = mdcp_pkg::PH_COMMAND;
        end
      end
      default: ;
    endcase

    trunc = stream_last && (phase_step inside {mdcp_pkg::PH_SIZE, mdcp_pkg::PH_OFFSET,
                                              mdcp_pkg::PH_LENGTH, mdcp_pkg::PH_PAYLOAD});
    entry.has_trunc = trunc;
    phase_next      = phase_step;

    // stream end: back to the version byte, codes kept
    if (stream_last) begin
      phase_next           = mdcp_pkg::PH_VERSION;
      field_cnt_next       = '0;
      field_acc_next       = '0;
      is_xor_next          = 1'b0;
      block_offset_next    = '0;
      bytes_remaining_next = '0;
    end
  end

  assign push = accept && (entry.has_main || entry.has_trunc);

endmodule

// ----- src/mdcp_queue.sv -----
module mdcp_queue #(
  parameter int DEPTH = mdcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mdcp_pkg::entry_t push_entry,
  input  logic             pop,
  output mdcp_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdcp_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/mdcp_back.sv -----
module mdcp_back (
  input  logic             clk,
  input  logic             rst,
  input  mdcp_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [2:0]       action,
  output logic [31:0]      target_address,
  output logic [31:0]      action_value,
  output logic [2:0]       error_kind,
  output logic             run_last
);

  logic sub, sub_next;
  logic load;
  logic take_main;

  assign load      = (!out_valid || out_ready) && !empty;
  assign take_main = !sub && head.has_main;
  assign pop       = load && !(take_main && head.has_trunc);

  always_comb begin
    sub_next = sub;
    if (load) begin
      sub_next = take_main && head.has_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      sub <= sub_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_main) begin
        action         <= head.action;
        target_address <= head.addr;
        action_value   <= head.value;
        error_kind     <= head.err;
        run_last       <= !head.has_trunc;
      end else begin
        action         <= mdcp_pkg::ACT_ERROR;
        target_address <= '0;
        action_value   <= '0;
        error_kind     <= mdcp_pkg::ERR_TRUNCATED;
        run_last       <= 1'b1;
      end
    end
  end

endmodule

// ----- src/mdcp_checker.sv -----
module mdcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic [31:0] target_address,
  input logic [31:0] action_value,
  input logic [2:0]  error_kind,
  input logic        run_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) &&
      $stable(target_address) && $stable(action_value) && $stable(run_last))
    else $error("stalled result changed");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != mdcp_pkg::ACT_ERROR |-> error_kind == mdcp_pkg::ERR_NONE)
    else $error("error kind on a non-error result");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == mdcp_pkg::ACT_ERROR |->
      error_kind != mdcp_pkg::ERR_NONE && target_address == 32'd0 && action_value == 32'd0)
    else $error("malformed error result");

  a_trunc_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid && action == mdcp_pkg::ACT_ERROR &&
      error_kind == mdcp_pkg::ERR_TRUNCATED && run_last)
    else $error("second result of a byte is not a truncation error");

endmodule

bind memory_delta_command_parser_unit mdcp_checker u_mdcp_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mdcp_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 4;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    action_t     act;
    logic [31:0] addr;
    logic [31:0] val;
    err_t        err;
    logic        last;
  } mem_action_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic        has;
    action_t     act;
    logic [31:0] val;
    err_t        err;
  } row_t;

  localparam logic [7:0] RESET_CODES [6] = '{8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0};

  // Default codes: version 1, size 1, compressed 2, overwrite 3, xor 4, end 0.
  localparam row_t DIRECTED [34] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, ACT_ERROR,    32'd0,        ERR_TOO_SHORT},
    '{8'h00, 1'b0, 1'b1, 1'b1, ACT_ERROR,    32'd0,        ERR_BAD_VER},
    '{8'hAA, 1'b1, 1'b1, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b1, 1'b1, ACT_SET_SIZE, 32'hFFFFFFFF, ERR_NONE},
    '{8'h03, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h77, 1'b0, 1'b1, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h04, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h02, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'hA5, 1'b1, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h00, 1'b1, 1'b1, 1'b1, ACT_END,      32'd0,        ERR_NONE},
    '{8'h01, 1'b0, 1'b0, 1'b0, ACT_SET_SIZE, 32'd0,        ERR_NONE},
    '{8'h02, 1'b1, 1'b1, 1'b1, ACT_ERROR,    32'd0,        ERR_COMPRESSED}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_VERSION;
  logic [7:0]             cfg_data = 8'd0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             stream_byte = 8'd0;
  logic                   stream_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready;
  logic [2:0]             action;
  logic [31:0]            target_address;
  logic [31:0]            action_value;
  logic [2:0]             error_kind;
  logic                   run_last;

  memory_delta_command_parser_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .stream_last    (stream_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .target_address (target_address),
    .action_value   (action_value),
    .error_kind     (error_kind),
    .run_last       (run_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // parser state mirror
  logic [7:0]  code_reg [6];
  logic [7:0]  phase_codes [6];
  phase_t      ph;
  logic [2:0]  fcnt;
  action_t     blk_act;
  logic [31:0] boff;
  logic [31:0] facc;
  logic [31:0] brem;
  logic [1:0]  bseen;

  mem_action_t byte_actions [$];
  mem_action_t pending_actions [$];
  logic [7:0]  stream_bytes [$];

  logic in_fire = 1'b0;
  logic no_idle = 1'b0;
  int   hold_reqs = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   sent = 0;

  function automatic void clear_parse_state();
    ph      = PH_VERSION;
    fcnt    = 3'd0;
    blk_act = ACT_SET_SIZE;
    boff    = 32'd0;
    facc    = 32'd0;
    brem    = 32'd0;
    bseen   = 2'd0;
  endfunction

  function automatic void add_action(action_t a, logic [31:0] ad, logic [31:0] v, err_t e);
    mem_action_t r;
    r.act  = a;
    r.addr = ad;
    r.val  = v;
    r.err  = e;
    r.last = 1'b0;
    byte_actions.insert(byte_actions.size(), r);
  endfunction

  function automatic logic take_field(input logic [7:0] b);
    logic [1:0] k;
    k = fcnt[1:0];
    facc = facc | (32'(b) << (8 * k));
    if (k == 2'd3) begin
      fcnt = 3'd0;
      return 1'b1;
    end
    fcnt = 3'(k) + 3'd1;
    return 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic l);
    mem_action_t r;
    byte_actions.delete();
    case (ph)
      PH_VERSION: begin
        if (l && bseen == 2'd0) begin
          add_action(ACT_ERROR, 32'd0, 32'd0, ERR_TOO_SHORT);
        end else if (b != code_reg[CFG_VERSION]) begin
          add_action(ACT_ERROR, 32'd0, 32'd0, ERR_BAD_VER);
          ph = PH_DRAIN;
        end else begin
          ph = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        fcnt = 3'd0;
        facc = 32'd0;
        if (b == code_reg[CFG_SIZE]) begin
          ph = PH_SIZE;
        end else if (b == code_reg[CFG_COMPRESSED]) begin
          add_action(ACT_ERROR, 32'd0, 32'd0, ERR_COMPRESSED);
          ph = PH_DRAIN;
        end else if (b == code_reg[CFG_OVERWRITE]) begin
          blk_act = ACT_OVERWRITE;
          ph = PH_OFFSET;
        end else if (b == code_reg[CFG_XOR]) begin
          blk_act = ACT_XOR;
          ph = PH_OFFSET;
        end else if (b == code_reg[CFG_END]) begin
          add_action(ACT_END, 32'd0, 32'd0, ERR_NONE);
          ph = PH_DRAIN;
        end
      end
      PH_SIZE: begin
        if (take_field(b)) begin
          add_action(ACT_SET_SIZE, 32'd0, facc, ERR_NONE);
          facc = 32'd0;
          ph = PH_COMMAND;
        end
      end
      PH_OFFSET: begin
        if (take_field(b)) begin
          boff = facc;
          facc = 32'd0;
          ph = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (take_field(b)) begin
          brem = facc;
          facc = 32'd0;
          ph = (brem != 32'd0) ? PH_PAYLOAD : PH_COMMAND;
        end
      end
      PH_PAYLOAD: begin
        add_action(blk_act, boff, 32'(b), ERR_NONE);
        boff = boff + 32'd1;
        brem = brem - 32'd1;
        if (brem == 32'd0) ph = PH_COMMAND;
      end
      default: ;
    endcase
    if (bseen < 2'd2) bseen = bseen + 2'd1;
    if (l) begin
      if (ph inside {PH_SIZE, PH_OFFSET, PH_LENGTH, PH_PAYLOAD})
        add_action(ACT_ERROR, 32'd0, 32'd0, ERR_TRUNCATED);
      clear_parse_state();
    end
    if (byte_actions.size() > 0) begin
      r = byte_actions.pop_back();
      r.last = 1'b1;
      byte_actions.insert(byte_actions.size(), r);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_action();
    mem_action_t w;
    if (pending_actions.size() == 0) begin
      note_mismatch($sformatf("unexpected result act=%0d addr=%h val=%h err=%0d last=%0b",
                              action, target_address, action_value, error_kind, run_last));
    end else begin
      w = pending_actions.pop_front();
      if (action !== w.act || target_address !== w.addr || action_value !== w.val ||
          error_kind !== w.err || run_last !== w.last)
        note_mismatch($sformatf(
          "exp act=%0d addr=%h val=%h err=%0d last=%0b, got act=%0d addr=%h val=%h err=%0d last=%0b",
          w.act, w.addr, w.val, w.err, w.last,
          action, target_address, action_value, error_kind, run_last));
    end
  endtask

  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) check_action();
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL memory_delta_command_parser_unit");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // result sink: random stalls, quiet windows, and long hold-offs on request
  initial begin : sink
    int   stall;
    int   window;
    int   holds_done;
    logic steady;
    stall = 0;
    window = 0;
    holds_done = 0;
    steady = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (window == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        window = 97;
      end else begin
        window--;
      end
      if (stall == 0 && !steady && $urandom_range(0, 2) == 0) stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [7:0] b, input logic l);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    stream_last <= l;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
  endtask

  task automatic queue_prediction();
    foreach (byte_actions[k]) pending_actions.insert(pending_actions.size(), byte_actions[k]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    parse_byte(b, l);
    queue_prediction();
    offer(b, l);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_codes();
    for (int i = CFG_VERSION; i <= CFG_END; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= phase_codes[i];
      code_reg[i] = phase_codes[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) stream_bytes.insert(stream_bytes.size(), w[8*k +: 8]);
  endfunction

  function automatic logic [7:0] unknown_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == code_reg[CFG_SIZE] || v == code_reg[CFG_COMPRESSED] ||
           v == code_reg[CFG_OVERWRITE] || v == code_reg[CFG_XOR] || v == code_reg[CFG_END]);
    return v;
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r < 3) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic void build_stream();
    int kind;
    int len;
    int cut;
    stream_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
      return;
    end
    stream_bytes.insert(stream_bytes.size(),
                        kind < 10 ? 8'($urandom_range(0, 255)) : code_reg[CFG_VERSION]);
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 19);
      if (kind < 4) begin
        stream_bytes.insert(stream_bytes.size(), code_reg[CFG_SIZE]);
        push_word(pick_word());
      end else if (kind < 16) begin
        stream_bytes.insert(stream_bytes.size(),
                            kind < 10 ? code_reg[CFG_OVERWRITE] : code_reg[CFG_XOR]);
        push_word(pick_word());
        len = pick_len();
        push_word(32'(len));
        repeat (len) stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
      end else if (kind < 19) begin
        stream_bytes.insert(stream_bytes.size(), unknown_byte());
      end else begin
        stream_bytes.insert(stream_bytes.size(), code_reg[CFG_COMPRESSED]);
      end
    end
    if ($urandom_range(0, 9) < 8) begin
      stream_bytes.insert(stream_bytes.size(), code_reg[CFG_END]);
      repeat ($urandom_range(0, 2))
        stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
  endfunction

  task automatic send_stream();
    no_idle = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < stream_bytes.size(); k++)
      send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
  endtask

  initial begin : main_seq
    row_t        row;
    logic        hold_asked;
    mem_action_t exp_row;
    code_reg = RESET_CODES;
    clear_parse_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      parse_byte(row.b, row.l);
      if (row.typed) begin
        if (byte_actions.size() != (row.has ? 1 : 0) ||
            (row.has && (byte_actions[0].act != row.act || byte_actions[0].val != row.val ||
                         byte_actions[0].err != row.err)))
          note_mismatch($sformatf(
            "directed item %0d: exp has=%0b act=%0d val=%h err=%0d, predicted %0d results",
            i, row.has, row.act, row.val, row.err, byte_actions.size()));
        byte_actions.delete();
        if (row.has) begin
          exp_row.act  = row.act;
          exp_row.addr = 32'd0;
          exp_row.val  = row.val;
          exp_row.err  = row.err;
          exp_row.last = 1'b1;
          byte_actions.insert(byte_actions.size(), exp_row);
        end
      end
      queue_prediction();
      offer(row.b, row.l);
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_codes = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
        1: phase_codes = '{8'h00, 8'hFF, 8'h5C, 8'h00, 8'hFE, 8'hFF};
        2: foreach (phase_codes[k]) phase_codes[k] = 8'($urandom_range(0, 255));
        default: foreach (phase_codes[k]) phase_codes[k] = 8'($urandom_range(0, 3));
      endcase
      load_codes();
      sent = 0;
      hold_asked = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_stream();
        send_stream();
        if (p % 2 == 0 && !hold_asked && sent > 20) begin
          hold_reqs <= hold_reqs + 1;
          hold_asked = 1'b1;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS memory_delta_command_parser_unit");
    end else begin
      $display("FAIL memory_delta_command_parser_unit");
    end
    $finish;
  end

endmodule
